[rtl/core/transposition_table_engine_assert.svh]
// Assertion macros shared by the checker of the transposition table engine.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TRANSPOSITION_TABLE_ENGINE_ASSERT_SVH
`define TRANSPOSITION_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define TTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tte_pkg.sv]
// Package of the transposition table engine: sizes, codes, entry layout and
// the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tte_pkg;

	localparam int SLOT_W     = 12;
	localparam int ENTRIES    = 1 << SLOT_W;
	localparam int PROBES     = 16;
	localparam int SCORE_BITS = 16;
	localparam int MEM_DEPTH  = 2 * ENTRIES;
	localparam int ADDR_W     = SLOT_W + 1;
	localparam int CNT_W      = $clog2(PROBES + 1);
	localparam int OUT_SLOT_W = 12;

	typedef enum logic [2:0] {
		ST_FRESH  = 3'd0,
		ST_INFER  = 3'd1,
		ST_STALE  = 3'd2,
		ST_STOMP  = 3'd3,
		ST_FAILED = 3'd4,
		ST_HIT    = 3'd5,
		ST_MISS   = 3'd6,
		ST_AGED   = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REQ_STORE  = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_AGE    = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		PASS_ONE   = 2'd0,
		PASS_TWO   = 2'd1,
		PASS_THREE = 2'd2
	} pass_t;

	typedef struct packed {
		logic [31:0]                   key;
		logic [5:0]                    depth;
		logic [5:0]                    future;
		logic [7:0]                    from_sq;
		logic [7:0]                    to_sq;
		logic signed [SCORE_BITS-1:0]  score;
		logic signed [SCORE_BITS-1:0]  low;
		logic signed [SCORE_BITS-1:0]  high;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef struct packed {
		logic load;
		logic sweep;
		logic sweep_clear;
		logic probe_start;
		logic probe;
		logic write;
		logic quick;
		logic aged;
		logic publish;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic key_zero;
		logic sweep_last;
		logic decide;
		logic need_write;
		logic out_busy;
	} sts_t;

	function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] slot);
		logic [SLOT_W+OUT_SLOT_W-1:0] wide;
		wide = (SLOT_W + OUT_SLOT_W)'(slot);
		return wide[OUT_SLOT_W-1:0];
	endfunction

endpackage

[rtl/core/tte_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[rtl/core/tte_ctrl.sv]
// Controller of the transposition table engine: clearing pass, aging sweep,
// probe sequencing and result hand-off. Depends on tte_pkg.
`timescale 1ns / 1ps

module tte_ctrl import tte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_CLEAR    = 7'b0000001,
		S_IDLE     = 7'b0000010,
		S_DISPATCH = 7'b0000100,
		S_AGE      = 7'b0001000,
		S_PROBE    = 7'b0010000,
		S_WRITE    = 7'b0100000,
		S_RESULT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep       = 1'b1;
				cmd.sweep_clear = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.req)
					REQ_AGE: begin
						state_d = S_AGE;
					end
					REQ_STORE, REQ_LOOKUP: begin
						if (sts.key_zero) begin
							cmd.quick = 1'b1;
							state_d   = S_RESULT;
						end else begin
							cmd.probe_start = 1'b1;
							state_d         = S_PROBE;
						end
					end
					default: begin
						cmd.quick = 1'b1;
						state_d   = S_RESULT;
					end
				endcase
			end
			S_AGE: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					cmd.aged = 1'b1;
					state_d  = S_RESULT;
				end
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.decide) begin
					state_d = sts.need_write ? S_WRITE : S_RESULT;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

[rtl/core/tte_dp.sv]
// Datapath of the transposition table engine: request registers, probe address
// generation, entry compare, table RAMs and output register. Depends on tte_pkg, tte_ram.
`timescale 1ns / 1ps

module tte_dp import tte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         req_type,
	input  logic               side,
	input  logic [31:0]        hash_code,
	input  logic [5:0]         search_level,
	input  logic [5:0]         remaining_depth,
	input  logic [7:0]         move_from,
	input  logic [7:0]         move_to,
	input  logic signed [15:0] move_score,
	input  logic signed [15:0] window_low,
	input  logic signed [15:0] window_high,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [11:0]        slot_index,
	output logic [5:0]         found_depth,
	output logic [5:0]         found_future,
	output logic               found_stale,
	output logic [7:0]         found_from,
	output logic [7:0]         found_to,
	output logic signed [15:0] found_score,
	output logic signed [15:0] found_low,
	output logic signed [15:0] found_high
);

	req_t               req_q;
	logic               side_q;
	logic [31:0]        key_q;
	logic [5:0]         dep_q, fut_q;
	logic [7:0]         from_q, to_q;
	logic signed [15:0] score_q, low_q, high_q;

	logic [SLOT_W-1:0]  iss_slot_q;
	logic [CNT_W-1:0]   iss_cnt_q;
	pass_t              iss_pass_q;
	logic               iss_act_q;
	logic               iss_last;

	logic               v_s1, last_s1;
	logic [SLOT_W-1:0]  slot_s1;
	pass_t              pass_s1;

	logic [SLOT_W-1:0]  wr_slot_q;
	logic [ADDR_W-1:0]  sw_cnt_q;

	logic [ENT_W-1:0]   main_rdata, main_wdata;
	logic [ADDR_W-1:0]  mem_addr;
	logic               main_we, stale_we, stale_wdata, stale_rd;
	ent_t               rd, new_ent;

	logic signed [31:0] xs, xl, xh, ns, na, nb;
	logic               k_empty, k_match, old_in, new_in, p1_better, p3_better;
	logic               hit, wr;
	status_t            code;

	status_t            res_status_q;
	logic [11:0]        res_slot_q;
	ent_t               res_ent_q;
	logic               res_stale_q;
	logic               out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_t'(req_type);
			side_q  <= side;
			key_q   <= hash_code;
			dep_q   <= (search_level > remaining_depth) ? search_level - remaining_depth : 6'd0;
			fut_q   <= remaining_depth;
			from_q  <= move_from;
			to_q    <= move_to;
			score_q <= move_score;
			low_q   <= window_low;
			high_q  <= window_high;
		end
	end

	assign iss_last = (iss_cnt_q == CNT_W'(PROBES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_act_q  <= 1'b0;
			iss_slot_q <= '0;
			iss_cnt_q  <= '0;
			iss_pass_q <= PASS_ONE;
			v_s1       <= 1'b0;
			sw_cnt_q   <= '0;
		end else begin
			v_s1 <= cmd.probe && iss_act_q;
			if (cmd.sweep) begin
				sw_cnt_q <= sw_cnt_q + 1'b1;
			end
			if (cmd.probe_start) begin
				iss_slot_q <= key_q[SLOT_W-1:0];
				iss_cnt_q  <= '0;
				iss_pass_q <= PASS_ONE;
				iss_act_q  <= 1'b1;
			end else if (cmd.probe && iss_act_q) begin
				if (iss_last) begin
					iss_cnt_q <= '0;
					if (iss_pass_q == PASS_ONE && req_q != REQ_LOOKUP) begin
						iss_pass_q <= PASS_TWO;
						iss_slot_q <= key_q[SLOT_W-1:0];
					end else if (iss_pass_q == PASS_TWO) begin
						iss_pass_q <= PASS_THREE;
						iss_slot_q <= iss_slot_q + 1'b1;
					end else begin
						iss_act_q <= 1'b0;
					end
				end else begin
					iss_cnt_q  <= iss_cnt_q + 1'b1;
					iss_slot_q <= iss_slot_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= iss_slot_q;
		pass_s1 <= iss_pass_q;
		last_s1 <= iss_last && (req_q == REQ_LOOKUP || iss_pass_q == PASS_THREE);
	end

	assign new_ent.key     = key_q;
	assign new_ent.depth   = dep_q;
	assign new_ent.future  = fut_q;
	assign new_ent.from_sq = from_q;
	assign new_ent.to_sq   = to_q;
	assign new_ent.score   = SCORE_BITS'(score_q);
	assign new_ent.low     = SCORE_BITS'(low_q);
	assign new_ent.high    = SCORE_BITS'(high_q);

	assign main_we     = cmd.write || (cmd.sweep && cmd.sweep_clear);
	assign stale_we    = cmd.write || cmd.sweep;
	assign stale_wdata = cmd.sweep && !cmd.sweep_clear;
	assign main_wdata  = cmd.sweep ? '0 : new_ent;
	assign mem_addr    = cmd.sweep ? sw_cnt_q :
	                     cmd.write ? {side_q, wr_slot_q} : {side_q, iss_slot_q};

	tte_ram #(.WIDTH(ENT_W), .DEPTH(MEM_DEPTH)) u_main_ram (
		.clk   (clk),
		.we    (main_we),
		.addr  (mem_addr),
		.wdata (main_wdata),
		.rdata (main_rdata)
	);

	tte_ram #(.WIDTH(1), .DEPTH(MEM_DEPTH)) u_stale_ram (
		.clk   (clk),
		.we    (stale_we),
		.addr  (mem_addr),
		.wdata (stale_wdata),
		.rdata (stale_rd)
	);

	assign rd = ent_t'(main_rdata);

	assign xs = 32'($signed(rd.score));
	assign xl = 32'($signed(rd.low));
	assign xh = 32'($signed(rd.high));
	assign ns = 32'(score_q);
	assign na = 32'(low_q);
	assign nb = 32'(high_q);

	assign k_empty   = (rd.key == 32'd0);
	assign k_match   = (rd.key == key_q);
	assign old_in    = (xl <= xs) && (xs <= xh);
	assign new_in    = (na <= ns) && (ns <= nb);
	assign p1_better = (dep_q > rd.depth) ||
	                   ((dep_q == rd.depth) && !old_in && (new_in || fut_q < rd.future));
	assign p3_better = (dep_q > rd.depth) ||
	                   ((dep_q == rd.depth) && ((fut_q < rd.future) ||
	                   ((fut_q == rd.future) && (side_q ? (ns < xs) : (ns > xs)))));

	always_comb begin
		hit  = 1'b0;
		wr   = 1'b0;
		code = ST_FAILED;
		if (req_q == REQ_LOOKUP) begin
			code = ST_MISS;
			if (k_match) begin
				hit  = 1'b1;
				code = ST_HIT;
			end else if (k_empty) begin
				hit = 1'b1;
			end
		end else begin
			case (pass_s1)
				PASS_ONE: begin
					if (k_empty) begin
						hit  = 1'b1;
						wr   = 1'b1;
						code = ST_FRESH;
					end else if (k_match) begin
						hit  = 1'b1;
						wr   = p1_better;
						code = p1_better ? ST_FRESH : ST_INFER;
					end
				end
				PASS_TWO: begin
					if (stale_rd) begin
						hit  = 1'b1;
						wr   = 1'b1;
						code = ST_STALE;
					end
				end
				PASS_THREE: begin
					if (p3_better) begin
						hit  = 1'b1;
						wr   = 1'b1;
						code = ST_STOMP;
					end
				end
				default: begin
					hit = 1'b0;
				end
			endcase
		end
	end

	assign sts.req        = req_q;
	assign sts.key_zero   = (key_q == 32'd0);
	assign sts.sweep_last = &sw_cnt_q;
	assign sts.decide     = v_s1 && (hit || last_s1);
	assign sts.need_write = wr && hit;
	assign sts.out_busy   = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.probe && sts.decide) begin
			res_status_q <= code;
			wr_slot_q    <= slot_s1;
			if (hit && code != ST_MISS) begin
				res_slot_q <= slot_out(slot_s1);
			end else begin
				res_slot_q <= '0;
			end
			if (code == ST_HIT) begin
				res_ent_q   <= rd;
				res_stale_q <= stale_rd;
			end else begin
				res_ent_q   <= '0;
				res_stale_q <= 1'b0;
			end
		end else if (cmd.quick || cmd.aged) begin
			if (cmd.aged) begin
				res_status_q <= ST_AGED;
			end else begin
				res_status_q <= (req_q == REQ_STORE) ? ST_FAILED : ST_MISS;
			end
			res_slot_q  <= '0;
			res_ent_q   <= '0;
			res_stale_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status       <= res_status_q;
			slot_index   <= res_slot_q;
			found_depth  <= res_ent_q.depth;
			found_future <= res_ent_q.future;
			found_stale  <= res_stale_q;
			found_from   <= res_ent_q.from_sq;
			found_to     <= res_ent_q.to_sq;
			found_score  <= 16'(res_ent_q.score);
			found_low    <= 16'(res_ent_q.low);
			found_high   <= 16'(res_ent_q.high);
		end
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/core/transposition_table_engine.sv]
// Top level of the transposition table engine: two linear-probing tables, one per side.
// Depends on tte_pkg, tte_ctrl, tte_dp.
//
//   channel  handshake           word
//   input    in_valid/in_stall   req_type, side, hash_code, depths, move, window
//   output   out_valid/out_stall status, slot_index, found_* fields
//
// After reset a clearing pass writes all 2*ENTRIES slots, one per cycle, with the input stalled.
// A lookup probes up to PROBES slots and a store up to 3*PROBES slots in three passes, one table read per cycle.
// An aging request sweeps the stale bits of all 2*ENTRIES slots, one per cycle.
// The next word is taken while a result still waits in the output register.
`timescale 1ns / 1ps

module transposition_table_engine import tte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic               side,
	input  logic [31:0]        hash_code,
	input  logic [5:0]         search_level,
	input  logic [5:0]         remaining_depth,
	input  logic [7:0]         move_from,
	input  logic [7:0]         move_to,
	input  logic signed [15:0] move_score,
	input  logic signed [15:0] window_low,
	input  logic signed [15:0] window_high,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [11:0]        slot_index,
	output logic [5:0]         found_depth,
	output logic [5:0]         found_future,
	output logic               found_stale,
	output logic [7:0]         found_from,
	output logic [7:0]         found_to,
	output logic signed [15:0] found_score,
	output logic signed [15:0] found_low,
	output logic signed [15:0] found_high
);

	cmd_t cmd;
	sts_t sts;

	tte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tte_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_type        (req_type),
		.side            (side),
		.hash_code       (hash_code),
		.search_level    (search_level),
		.remaining_depth (remaining_depth),
		.move_from       (move_from),
		.move_to         (move_to),
		.move_score      (move_score),
		.window_low      (window_low),
		.window_high     (window_high),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.slot_index      (slot_index),
		.found_depth     (found_depth),
		.found_future    (found_future),
		.found_stale     (found_stale),
		.found_from      (found_from),
		.found_to        (found_to),
		.found_score     (found_score),
		.found_low       (found_low),
		.found_high      (found_high)
	);

endmodule

[rtl/core/tte_checker.sv]
// Port-level checker of the transposition table engine and its bind to the top level.
// Depends on tte_pkg and transposition_table_engine_assert.svh.
`timescale 1ns / 1ps
`include "transposition_table_engine_assert.svh"

module tte_checker import tte_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         req_type,
	input logic               side,
	input logic [31:0]        hash_code,
	input logic [5:0]         search_level,
	input logic [5:0]         remaining_depth,
	input logic [7:0]         move_from,
	input logic [7:0]         move_to,
	input logic signed [15:0] move_score,
	input logic signed [15:0] window_low,
	input logic signed [15:0] window_high,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic [11:0]        slot_index,
	input logic [5:0]         found_depth,
	input logic [5:0]         found_future,
	input logic               found_stale,
	input logic [7:0]         found_from,
	input logic [7:0]         found_to,
	input logic signed [15:0] found_score,
	input logic signed [15:0] found_low,
	input logic signed [15:0] found_high
);

	`TTE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(slot_index), "stalled result word changed")
	`TTE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again while a word is in work")
	`TTE_ASSERT_NOW(a_fields_zero, out_valid && status != ST_HIT, found_depth == 6'd0 && found_future == 6'd0 && found_stale == 1'b0 && found_score == 16'sd0 && found_low == 16'sd0 && found_high == 16'sd0, "entry fields set without a hit")
	`TTE_ASSERT_NOW(a_slot_zero, out_valid && (status == ST_FAILED || status == ST_MISS || status == ST_AGED), slot_index == 12'd0, "slot index set on a result without a slot")

endmodule

bind transposition_table_engine tte_checker u_tte_checker (.*);
